### sv/lzx_pkg.sv
// ----------------------------------------------------------------------------
// lzx_pkg
// Shared constants and types for the LZ extension byte decompressor.
// ----------------------------------------------------------------------------
package lzx_pkg;

    localparam int unsigned LZX_WINDOW_BYTES = 4096;

    // result status codes
    localparam logic [2:0] ST_BYTE          = 3'd0;
    localparam logic [2:0] ST_NO_OUTPUT     = 3'd1;
    localparam logic [2:0] ST_BEFORE_START  = 3'd2;
    localparam logic [2:0] ST_BEYOND_WINDOW = 3'd3;
    localparam logic [2:0] ST_DROPPED       = 3'd4;

    // item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // request from the decoder to the resolve/output stage
    typedef struct packed {
        logic       load;      // a result goes down the pipe this cycle
        logic       write;     // the result byte enters the window
        logic       from_mem;  // result byte comes from the window read
        logic [2:0] status;
        logic       more;
        logic       done;
        logic [7:0] lit_byte;  // literal byte, zero on non-byte results
    } t_lzx_req;

endpackage

### sv/lz_extension_byte_decompressor.sv
// ----------------------------------------------------------------------------
// lz_extension_byte_decompressor
// LZ back-reference decompressor with extension prefix bytes.
// ----------------------------------------------------------------------------
// An accepted request passes the stage register, then the output register.
// Throughput: one request per cycle without output stall, set by the single
//   window read and write; copy bytes forward from the write in flight.
// Reset: synchronous, active low; clears all decode state and the halt
//   flag. The history window is not cleared and needs no pass.
module lz_extension_byte_decompressor
    import lzx_pkg::*;
#(
    parameter int unsigned WINDOW_BYTES = LZX_WINDOW_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_status,
    output logic        o_more_pending,
    output logic        o_done_res,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    localparam int unsigned AW = $clog2(WINDOW_BYTES);

    t_lzx_req      req;
    logic          accept;
    logic          rd_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          ram_we;
    logic [AW-1:0] ram_wa;
    logic [7:0]    ram_wd, ram_rd;

    assign accept = i_in_valid && !o_in_stall;

    lzx_ctrl #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .AW           (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_req       (req),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr)
    );

    lzx_window_ram #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .AW           (AW)
    ) u_ram (
        .i_clk (i_clk),
        .i_we  (ram_we),
        .i_wa  (ram_wa),
        .i_wd  (ram_wd),
        .i_re  (rd_en),
        .i_ra  (rd_addr),
        .o_rd  (ram_rd)
    );

    lzx_out_stage #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .AW           (AW)
    ) u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req),
        .i_wr_addr      (wr_addr),
        .i_rd_en        (rd_en),
        .i_rd_addr      (rd_addr),
        .i_ram_rd       (ram_rd),
        .o_ram_we       (ram_we),
        .o_ram_wa       (ram_wa),
        .o_ram_wd       (ram_wd),
        .o_in_stall     (o_in_stall),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_status       (o_status),
        .o_more_pending (o_more_pending),
        .o_done_res     (o_done_res)
    );

endmodule

### sv/lzx_window_ram.sv
// ----------------------------------------------------------------------------
// lzx_window_ram
// History window: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lzx_window_ram
    import lzx_pkg::*;
#(
    parameter int unsigned WINDOW_BYTES = LZX_WINDOW_BYTES,
    parameter int unsigned AW           = $clog2(WINDOW_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wa,
    input  logic [7:0]    i_wd,
    input  logic          i_re,
    input  logic [AW-1:0] i_ra,
    output logic [7:0]    o_rd
);

    logic [7:0] r_mem [WINDOW_BYTES];
    logic [7:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        // read returns old data on a same-address write; caller forwards
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_rd = r_rd;

endmodule

### sv/lzx_ctrl.sv
// ----------------------------------------------------------------------------
// lzx_ctrl
// Operation decoder: extension prefixes, literal runs, copy setup and
// stepping, output count and window write pointer.
// ----------------------------------------------------------------------------
module lzx_ctrl
    import lzx_pkg::*;
#(
    parameter int unsigned WINDOW_BYTES = LZX_WINDOW_BYTES,
    parameter int unsigned AW           = $clog2(WINDOW_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_kind,
    input  logic [7:0]    i_data_byte,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    output t_lzx_req      o_req,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    output logic [AW-1:0] o_wr_addr
);

    localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_BYTES - 1);
    localparam logic [AW:0]   SUM_BIAS = (AW+1)'(WINDOW_BYTES - 1);
    localparam logic [AW:0]   WIN_W    = (AW+1)'(WINDOW_BYTES);
    localparam logic [31:0]   WIN_32   = 32'(WINDOW_BYTES);

    logic [31:0]   r_exp, r_off, r_run, r_opc, r_lit, r_copy, r_oc;
    logic [31:0]   n_off, n_run, n_opc, n_lit, n_copy, n_oc;
    logic [AW-1:0] r_csi, r_wi, n_csi, n_wi;
    logic          r_halted, n_halted;

    logic [31:0]   opc_inc, copy_dist, len;
    logic [AW:0]   src_sum;
    logic [AW-1:0] src_idx, cp_src;
    logic [31:0]   cp_left;
    logic          do_copy, emit;
    t_lzx_req      req;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        wrap_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    assign opc_inc   = r_opc + 32'd1;
    assign copy_dist = {r_off[27:0], i_data_byte[3:0]};
    assign len       = {r_run[28:0], i_data_byte[6:4]} + opc_inc + 32'd1;
    // source sits copy_dist places before the last written byte
    assign src_sum = {1'b0, r_wi} + SUM_BIAS - copy_dist[AW:0];
    assign src_idx = (src_sum >= WIN_W) ? AW'(src_sum - WIN_W) : src_sum[AW-1:0];

    always_comb begin
        n_off    = r_off;
        n_run    = r_run;
        n_opc    = r_opc;
        n_lit    = r_lit;
        n_copy   = r_copy;
        n_oc     = r_oc;
        n_csi    = r_csi;
        n_wi     = r_wi;
        n_halted = r_halted;
        req      = '0;
        do_copy  = 1'b0;
        emit     = 1'b0;
        cp_src   = r_csi;
        cp_left  = r_copy;
        o_rd_en  = 1'b0;

        if (i_accept && !r_halted) begin
            if (i_kind == KIND_TICK) begin
                do_copy = (r_copy != 32'd0);
            end else if (r_copy != 32'd0) begin
                // drop stream byte while a copy is pending
                req.load   = 1'b1;
                req.status = ST_DROPPED;
                req.more   = 1'b1;
            end else if (r_lit != 32'd0) begin
                n_lit        = r_lit - 32'd1;
                emit         = 1'b1;
                req.lit_byte = i_data_byte;
            end else if (r_oc < r_exp) begin
                n_opc = opc_inc;
                if (i_data_byte[7]) begin
                    if (i_data_byte[6]) begin
                        n_off = {r_off[25:0], i_data_byte[5:0]};
                    end else if (i_data_byte[5]) begin
                        n_run = {r_run[26:0], i_data_byte[4:0]};
                    end else if (i_data_byte[4]) begin
                        n_off = {r_off[29:0], i_data_byte[3:2]};
                        n_run = {r_run[29:0], i_data_byte[1:0]};
                    end else begin
                        n_lit = {r_run[27:0], i_data_byte[3:0]} + 32'd1;
                        n_opc = '0;
                        n_off = '0;
                        n_run = '0;
                    end
                end else if (r_oc == 32'd0) begin
                    n_halted   = 1'b1;
                    req.load   = 1'b1;
                    req.status = ST_NO_OUTPUT;
                end else if (copy_dist >= r_oc) begin
                    n_halted   = 1'b1;
                    req.load   = 1'b1;
                    req.status = ST_BEFORE_START;
                end else if (copy_dist >= WIN_32) begin
                    n_halted   = 1'b1;
                    req.load   = 1'b1;
                    req.status = ST_BEYOND_WINDOW;
                end else begin
                    n_opc   = '0;
                    n_off   = '0;
                    n_run   = '0;
                    n_csi   = src_idx;
                    n_copy  = len;
                    cp_src  = src_idx;
                    cp_left = len;
                    do_copy = (len != 32'd0);
                end
            end
        end

        if (do_copy) begin
            o_rd_en      = 1'b1;
            n_csi        = wrap_inc(cp_src);
            n_copy       = cp_left - 32'd1;
            emit         = 1'b1;
            req.from_mem = 1'b1;
        end

        if (emit) begin
            n_wi       = wrap_inc(r_wi);
            n_oc       = (r_oc == 32'hFFFF_FFFF) ? r_oc : r_oc + 32'd1;
            req.load   = 1'b1;
            req.write  = 1'b1;
            req.status = ST_BYTE;
            req.more   = (n_copy != 32'd0);
            req.done   = (n_lit == 32'd0) && (n_copy == 32'd0) && (n_oc >= r_exp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp    <= '0;
            r_off    <= '0;
            r_run    <= '0;
            r_opc    <= '0;
            r_lit    <= '0;
            r_copy   <= '0;
            r_oc     <= '0;
            r_csi    <= '0;
            r_wi     <= '0;
            r_halted <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_exp <= i_cfg_wdata;
            end
            r_off    <= n_off;
            r_run    <= n_run;
            r_opc    <= n_opc;
            r_lit    <= n_lit;
            r_copy   <= n_copy;
            r_oc     <= n_oc;
            r_csi    <= n_csi;
            r_wi     <= n_wi;
            r_halted <= n_halted;
        end
    end

    assign o_req     = req;
    assign o_rd_addr = cp_src;
    assign o_wr_addr = r_wi;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");

    a_drop_needs_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.load && req.status == ST_DROPPED |-> r_copy != 32'd0)
        else $error("dropped byte reported with no copy pending");

    a_wptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wi <= LAST_IDX && r_csi <= LAST_IDX)
        else $error("window pointer outside window");

    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !req.load)
        else $error("result produced while halted");

endmodule

### sv/lzx_out_stage.sv
// ----------------------------------------------------------------------------
// lzx_out_stage
// Resolves the result byte from the literal, the window read or a forwarded write,
// writes it back to the window and holds it in the output register.
// ----------------------------------------------------------------------------
module lzx_out_stage
    import lzx_pkg::*;
#(
    parameter int unsigned WINDOW_BYTES = LZX_WINDOW_BYTES,
    parameter int unsigned AW           = $clog2(WINDOW_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_lzx_req      i_req,
    input  logic [AW-1:0] i_wr_addr,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [7:0]    i_ram_rd,
    output logic          o_ram_we,
    output logic [AW-1:0] o_ram_wa,
    output logic [7:0]    o_ram_wd,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [7:0]    o_out_byte,
    output logic [2:0]    o_status,
    output logic          o_more_pending,
    output logic          o_done_res
);

    t_lzx_req      r_s1;
    logic          r_s1_valid;
    logic [AW-1:0] r_s1_wa;
    logic          r_fwd_hit;
    logic [7:0]    r_fwd_data;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic [2:0]    r_status;
    logic          r_more, r_done;

    logic          s1_fire;
    logic [7:0]    s1_data;

    assign s1_fire    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign s1_data    = !r_s1.from_mem ? r_s1.lit_byte :
                        (r_fwd_hit ? r_fwd_data : i_ram_rd);
    assign o_in_stall = r_s1_valid && !s1_fire;

    assign o_ram_we = s1_fire && r_s1.write;
    assign o_ram_wa = r_s1_wa;
    assign o_ram_wd = s1_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.load) begin
            r_s1    <= i_req;
            r_s1_wa <= i_wr_addr;
            // read collides with the write leaving this cycle: forward it
            r_fwd_hit  <= i_rd_en && s1_fire && r_s1.write && (r_s1_wa == i_rd_addr);
            r_fwd_data <= s1_data;
        end
        if (s1_fire) begin
            r_out_byte <= s1_data;
            r_status   <= r_s1.status;
            r_more     <= r_s1.more;
            r_done     <= r_s1.done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_status       = r_status;
    assign o_more_pending = r_more;
    assign o_done_res     = r_done;

    a_write_only_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> r_s1.status == ST_BYTE)
        else $error("window written by a non-byte result");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_fire |-> !i_req.load)
        else $error("request loaded over a held stage");

    a_fwd_from_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_fwd_hit |-> r_s1.from_mem)
        else $error("forward flagged on a literal result");

endmodule
